[rtl/atcw_pkg.sv]
`default_nettype none

package atcw_pkg;

  // Geometry of the cell store.
  localparam int ROWS      = 64;
  localparam int COLS      = 128;
  localparam int PARAM_BUF = 16;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int CCNT_W = $clog2(COLS + 1);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int PCNT_W = $clog2(PARAM_BUF);
  localparam int CELL_W = 11;

  // Command queue between the parser and the cell engine.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Saturation limit of the CSI value.
  localparam logic [6:0] VAL_MAX = 7'd127;

  // Stored cell: colour in the top bits, character below.
  localparam logic [CELL_W-1:0] SPACE_CELL = 11'h020;

  // Parser modes.
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_CSI    = 2'd2;

  // Characters of interest.
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] FIN_LO   = 8'h40;
  localparam logic [7:0] FIN_HI   = 8'h7e;
  localparam logic [7:0] FIN_M    = 8'h6d;
  localparam logic [7:0] FIN_K    = 8'h4b;
  localparam logic [7:0] FIN_J    = 8'h4a;
  localparam logic [7:0] FIN_H    = 8'h48;

  // Palette indexes.
  localparam logic [2:0] COLOR_DEFAULT = 3'd0;
  localparam logic [2:0] COLOR_GREEN   = 3'd1;
  localparam logic [2:0] COLOR_YELLOW  = 3'd2;
  localparam logic [2:0] COLOR_MAGENTA = 3'd3;
  localparam logic [2:0] COLOR_GREY    = 3'd4;

  // Cell engine operations.
  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_READ     = 3'd1;
  localparam logic [2:0] OP_CELLS    = 3'd2;
  localparam logic [2:0] OP_ERASE    = 3'd3;
  localparam logic [2:0] OP_NEWROW   = 3'd4;
  localparam logic [2:0] OP_CLEARALL = 3'd5;

  // One command for the cell engine, with the cursor state after the item.
  typedef struct packed {
    logic [2:0]        op;
    logic              fresh;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CCNT_W-1:0] col_end;
    logic [7:0]        ch;
    logic [2:0]        color;
    logic [ROW_W-1:0]  cur_row;
    logic [CCNT_W-1:0] cur_col;
    logic [2:0]        pen;
    logic [1:0]        mode;
  } cmd_t;

  // SGR value to palette index.
  function automatic logic [2:0] color_of(input logic [6:0] v);
    logic [2:0] c;
    case (v)
      7'd32:   c = COLOR_GREEN;
      7'd33:   c = COLOR_YELLOW;
      7'd35:   c = COLOR_MAGENTA;
      7'd90:   c = COLOR_GREY;
      default: c = COLOR_DEFAULT;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/atcw_queue.sv]
`default_nettype none

module atcw_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push_en,
  input  atcw_pkg::cmd_t   push_data,
  output logic             full,
  input  wire              pop_en,
  output atcw_pkg::cmd_t   pop_data,
  output logic             empty
);
  import atcw_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == (QPTR_W + 1)'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rptr];
  assign do_push  = push_en && !full;
  assign do_pop   = pop_en && !empty;

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/atcw_front.sv]
`default_nettype none

module atcw_front (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        accept,
  input  wire                        req_type,
  input  wire  [7:0]                 data_byte,
  input  wire  [atcw_pkg::ROW_W-1:0] read_row,
  input  wire  [atcw_pkg::COL_W-1:0] read_col,
  output atcw_pkg::cmd_t             cmd
);
  import atcw_pkg::*;

  logic [ROW_W-1:0]  write_row;
  logic [CCNT_W-1:0] write_col;
  logic [2:0]        current_color;
  logic [1:0]        escape_mode;
  logic [PCNT_W-1:0] param_count;
  logic [6:0]        param_value;
  logic              param_digits_done;

  logic [ROW_W-1:0]  write_row_next;
  logic [CCNT_W-1:0] write_col_next;
  logic [2:0]        current_color_next;
  logic [1:0]        escape_mode_next;
  logic [PCNT_W-1:0] param_count_next;
  logic [6:0]        param_value_next;
  logic              param_digits_done_next;

  logic [ROW_W-1:0]  row_inc;
  logic [10:0]       acc;
  logic [CCNT_W:0]   tab_stop;
  logic [CCNT_W-1:0] place_col;

  // Ring successor of the current row.
  assign row_inc = (int'(write_row) == ROWS - 1) ? '0 : write_row + 1'b1;

  // Classify the byte, update the cursor and parser, and build the command.
  always_comb begin
    write_row_next         = write_row;
    write_col_next         = write_col;
    current_color_next     = current_color;
    escape_mode_next       = escape_mode;
    param_count_next       = param_count;
    param_value_next       = param_value;
    param_digits_done_next = param_digits_done;
    acc       = 11'(param_value) * 11'd10 + 11'(data_byte - CH_ZERO);
    tab_stop  = ((CCNT_W + 1)'(write_col) + (CCNT_W + 1)'(8)) & ~(CCNT_W + 1)'(7);
    place_col = (int'(write_col) >= COLS) ? '0 : write_col;

    cmd         = '0;
    cmd.op      = OP_NONE;
    cmd.row     = write_row;
    cmd.col     = write_col[COL_W-1:0];
    cmd.ch      = data_byte;
    cmd.color   = current_color;

    if (req_type) begin
      cmd.op  = OP_READ;
      cmd.row = read_row;
      cmd.col = read_col;
    end else if (escape_mode == MODE_ESC) begin
      escape_mode_next       = (data_byte == CH_LBR) ? MODE_CSI : MODE_NORMAL;
      param_count_next       = '0;
      param_value_next       = '0;
      param_digits_done_next = 1'b0;
    end else if (escape_mode == MODE_CSI) begin
      if (data_byte >= FIN_LO && data_byte <= FIN_HI) begin
        escape_mode_next = MODE_NORMAL;
        case (data_byte)
          FIN_M: begin
            current_color_next = color_of(param_value);
          end
          FIN_K: begin
            if (int'(write_col) < COLS) begin
              cmd.op = OP_ERASE;
            end
          end
          FIN_J: begin
            cmd.op         = OP_CLEARALL;
            write_row_next = '0;
            write_col_next = '0;
          end
          FIN_H: begin
            write_col_next = '0;
          end
          default: begin
          end
        endcase
      end else if (int'(param_count) < PARAM_BUF - 1) begin
        param_count_next = param_count + 1'b1;
        if (!param_digits_done) begin
          if (data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
            param_value_next = (acc > 11'(VAL_MAX)) ? VAL_MAX : acc[6:0];
          end else begin
            param_digits_done_next = 1'b1;
          end
        end
      end
    end else begin
      case (data_byte)
        CH_ESC: begin
          escape_mode_next = MODE_ESC;
        end
        CH_LF: begin
          write_row_next = row_inc;
          write_col_next = '0;
          cmd.op         = OP_NEWROW;
          cmd.row        = row_inc;
        end
        CH_CR: begin
          write_col_next = '0;
        end
        CH_BS: begin
          if (write_col != '0) begin
            write_col_next = write_col - 1'b1;
          end
        end
        CH_TAB: begin
          if (int'(write_col) < COLS) begin
            cmd.op         = OP_CELLS;
            cmd.ch         = CH_SPACE;
            cmd.col_end    = tab_stop[CCNT_W-1:0];
            write_col_next = tab_stop[CCNT_W-1:0];
          end
        end
        default: begin
          if (data_byte >= CH_SPACE) begin
            // A full line wraps to a fresh row before the character lands.
            if (int'(write_col) >= COLS) begin
              write_row_next = row_inc;
              cmd.fresh      = 1'b1;
              cmd.row        = row_inc;
            end
            cmd.op         = OP_CELLS;
            cmd.col        = place_col[COL_W-1:0];
            cmd.col_end    = place_col + 1'b1;
            write_col_next = place_col + 1'b1;
          end
        end
      endcase
    end

    cmd.cur_row = write_row_next;
    cmd.cur_col = write_col_next;
    cmd.pen     = current_color_next;
    cmd.mode    = escape_mode_next;
  end

  // Cursor and parser registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_row         <= '0;
      write_col         <= '0;
      current_color     <= COLOR_DEFAULT;
      escape_mode       <= MODE_NORMAL;
      param_count       <= '0;
      param_value       <= '0;
      param_digits_done <= 1'b0;
    end else if (accept) begin
      write_row         <= write_row_next;
      write_col         <= write_col_next;
      current_color     <= current_color_next;
      escape_mode       <= escape_mode_next;
      param_count       <= param_count_next;
      param_value       <= param_value_next;
      param_digits_done <= param_digits_done_next;
    end
  end

endmodule

`default_nettype wire

[rtl/atcw_back.sv]
`default_nettype none

module atcw_back (
  input  wire                         clk,
  input  wire                         rst,
  input  atcw_pkg::cmd_t              q_data,
  input  wire                         q_empty,
  output logic                        q_pop,
  output logic                        empty,
  input  wire                         pop,
  output logic [7:0]                  cell_char,
  output logic [2:0]                  cell_color,
  output logic [atcw_pkg::ROW_W-1:0]  cursor_row,
  output logic [atcw_pkg::CCNT_W-1:0] cursor_col,
  output logic [2:0]                  pen_color,
  output logic [1:0]                  parse_mode
);
  import atcw_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_RDW   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [CELL_W-1:0] mem [ROWS*COLS];
  logic [CELL_W-1:0] rd_data;

  logic [2:0]        state;
  cmd_t              cmd;
  logic [ROWS-1:0]   row_valid;
  logic [CCNT_W-1:0] sweep_col;
  logic [CCNT_W-1:0] sweep_end;
  logic [CELL_W-1:0] sweep_cell;
  logic              fill_phase;
  logic [7:0]        res_char;
  logic [2:0]        res_color;
  logic              out_valid;
  logic              in_range;
  logic              out_free;
  logic              sweep_last;

  assign empty      = !out_valid;
  assign out_free   = !out_valid || pop;
  assign q_pop      = (state == S_IDLE) && !q_empty;
  assign in_range   = (int'(q_data.row) < ROWS) && (int'(q_data.col) < COLS);
  assign sweep_last = (sweep_col + 1'b1) == sweep_end;

  // Cell store: one write port for sweeps, one registered read port.
  always_ff @(posedge clk) begin
    if (state == S_SWEEP) begin
      mem[{cmd.row, sweep_col[COL_W-1:0]}] <= sweep_cell;
    end
    rd_data <= mem[{cmd.row, cmd.col}];
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      // A finished command refills the result register; otherwise a pop empties it.
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cmd <= q_data;
            // A read of a row that holds no live cells returns a blank.
            if (q_data.op == OP_READ && in_range && !row_valid[q_data.row]) begin
              res_char  <= SPACE_CELL[7:0];
              res_color <= SPACE_CELL[CELL_W-1:8];
            end else begin
              res_char  <= '0;
              res_color <= '0;
            end
            case (q_data.op)
              OP_NEWROW: begin
                row_valid[q_data.row] <= 1'b0;
                state                 <= S_DONE;
              end
              OP_CLEARALL: begin
                row_valid <= '0;
                state     <= S_DONE;
              end
              OP_ERASE: begin
                // An invalid row already reads as blanks.
                if (row_valid[q_data.row]) begin
                  sweep_col  <= CCNT_W'(q_data.col);
                  sweep_end  <= CCNT_W'(COLS);
                  sweep_cell <= SPACE_CELL;
                  fill_phase <= 1'b0;
                  state      <= S_SWEEP;
                end else begin
                  state <= S_DONE;
                end
              end
              OP_CELLS: begin
                if (row_valid[q_data.row] && !q_data.fresh) begin
                  sweep_col  <= CCNT_W'(q_data.col);
                  sweep_end  <= q_data.col_end;
                  sweep_cell <= {q_data.color, q_data.ch};
                  fill_phase <= 1'b0;
                end else begin
                  // Blank the whole row before the first cell lands in it.
                  row_valid[q_data.row] <= 1'b0;
                  sweep_col  <= '0;
                  sweep_end  <= CCNT_W'(COLS);
                  sweep_cell <= SPACE_CELL;
                  fill_phase <= 1'b1;
                end
                state <= S_SWEEP;
              end
              OP_READ: begin
                if (in_range && row_valid[q_data.row]) begin
                  state <= S_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SWEEP: begin
          if (sweep_last && fill_phase) begin
            row_valid[cmd.row] <= 1'b1;
            sweep_col  <= CCNT_W'(cmd.col);
            sweep_end  <= cmd.col_end;
            sweep_cell <= {cmd.color, cmd.ch};
            fill_phase <= 1'b0;
          end else begin
            sweep_col <= sweep_col + 1'b1;
            if (sweep_last) begin
              state <= S_DONE;
            end
          end
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          res_char  <= rd_data[7:0];
          res_color <= rd_data[CELL_W-1:8];
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      cell_char  <= res_char;
      cell_color <= res_color;
      cursor_row <= cmd.cur_row;
      cursor_col <= cmd.cur_col;
      pen_color  <= cmd.pen;
      parse_mode <= cmd.mode;
    end
  end

endmodule

`default_nettype wire

[rtl/ansi_text_cell_writer_core.sv]
`default_nettype none

// ANSI text cell writer. Each transaction is either one byte of a terminal
// output stream (req_type 0) or a read of one stored cell (req_type 1), and
// each one yields exactly one result carrying the read cell (zero for a byte
// write) and the cursor, pen colour and parser mode after that transaction.
// A parser front end takes one transaction per cycle, while the queue is not
// full, into a four-entry command queue; the cell engine behind it works
// through the commands one at a time. A printable byte runs through the
// engine's sweep state on the single write port of the cell store, and a
// read waits in the S_RD and S_RDW states for its registered read port.
// Rows are blanked lazily: newline, wrap and clear-screen only drop a
// per-row valid flag, and the first cell written into such a row first
// sweeps the whole row, one cell per cycle. Erase to end of line sweeps
// the rest of a live row at one cell per cycle, and a tab writes up to
// eight cells. Reset needs no clearing pass; the block takes transactions
// as soon as reset is released.
module ansi_text_cell_writer_core (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          push,
  output logic                         full,
  input  wire                          req_type,
  input  wire  [7:0]                   data_byte,
  input  wire  [atcw_pkg::ROW_W-1:0]   read_row,
  input  wire  [atcw_pkg::COL_W-1:0]   read_col,
  output logic                         empty,
  input  wire                          pop,
  output logic [7:0]                   cell_char,
  output logic [2:0]                   cell_color,
  output logic [atcw_pkg::ROW_W-1:0]   cursor_row,
  output logic [atcw_pkg::CCNT_W-1:0]  cursor_col,
  output logic [2:0]                   pen_color,
  output logic [1:0]                   parse_mode
);
  import atcw_pkg::*;

  cmd_t front_cmd;
  cmd_t q_data;
  logic q_empty;
  logic q_pop;
  logic accept;

  assign accept = push && !full;

  // Parser and cursor tracking.
  atcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (req_type),
    .data_byte (data_byte),
    .read_row  (read_row),
    .read_col  (read_col),
    .cmd       (front_cmd)
  );

  // Command queue between parser and cell engine.
  atcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (accept),
    .push_data (front_cmd),
    .full      (full),
    .pop_en    (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // Cell store engine and result register.
  atcw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (q_data),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .cell_char  (cell_char),
    .cell_color (cell_color),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .pen_color  (pen_color),
    .parse_mode (parse_mode)
  );

endmodule

`default_nettype wire
